// ===== hw/rtl/float_to_int_truncate_assert.svh =====
// Assertion macros used by the checker file.
`ifndef FLOAT_TO_INT_TRUNCATE_ASSERT_SVH
`define FLOAT_TO_INT_TRUNCATE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define F2I_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define F2I_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/f2i_pkg.sv =====
// ----------------------------------------------------------------------------
// f2i_pkg
// Types and constants for the single-precision to integer converter.
// ----------------------------------------------------------------------------
package f2i_pkg;

  localparam logic [1:0] FuncI8  = 2'd0;
  localparam logic [1:0] FuncI16 = 2'd1;
  localparam logic [1:0] FuncI32 = 2'd2;
  localparam logic [1:0] FuncI64 = 2'd3;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusInvalid  = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  localparam logic [63:0] MinI32Ext = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] MinI64    = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] real_bits;
  } f2i_in_t;

  typedef struct packed {
    logic signed [63:0] int_result;
    logic               ok_flag;
    logic [1:0]         status;
  } f2i_out_t;

endpackage

// ===== hw/rtl/f2i_convert.sv =====
// ----------------------------------------------------------------------------
// f2i_convert
// Combinational truncation of a single-precision value to a signed integer.
// ----------------------------------------------------------------------------
module f2i_convert import f2i_pkg::*; (
  input  f2i_in_t  item_i,
  output f2i_out_t res_o
);

  logic        neg;
  logic [7:0]  expo;
  logic [23:0] mant;
  logic [4:0]  rsh;
  logic [23:0] mag;
  logic        fits;

  assign neg  = item_i.real_bits[31];
  assign expo = item_i.real_bits[30:23];
  assign mant = {1'b1, item_i.real_bits[22:0]};
  // Right shift amount for exponents 0..23; larger ones never fit any target.
  assign rsh  = 5'(8'd150 - expo);

  always_comb begin
    mag  = 24'd0;
    fits = 1'b1;
    if (expo >= 8'd127 && expo <= 8'd150) begin
      mag = mant >> rsh;
    end
    if (expo > 8'd150) begin
      // Magnitude of at least 2^24 is out of range for every target.
      fits = 1'b0;
    end else begin
      case (item_i.func)
        FuncI8:  fits = neg ? (mag <= 24'd128) : (mag <= 24'd127);
        FuncI16: fits = neg ? (mag <= 24'd32768) : (mag <= 24'd32767);
        // The 24-bit magnitude is always strictly below 2^24 here.
        default: fits = 1'b1;
      endcase
    end
  end

  // Select the result: invalid first, then overflow, then the value.
  always_comb begin
    if (expo == 8'hFF) begin
      res_o.ok_flag = 1'b0;
      res_o.status  = StatusInvalid;
      case (item_i.func)
        FuncI32: res_o.int_result = MinI32Ext;
        FuncI64: res_o.int_result = MinI64;
        default: res_o.int_result = 64'sd0;
      endcase
    end else if (!fits) begin
      res_o.ok_flag    = 1'b0;
      res_o.status     = StatusOverflow;
      res_o.int_result = 64'sd0;
    end else begin
      res_o.ok_flag    = 1'b1;
      res_o.status     = StatusOk;
      res_o.int_result = neg ? -$signed({40'd0, mag}) : $signed({40'd0, mag});
    end
  end

endmodule

// ===== hw/rtl/float_to_int_truncate.sv =====
// ----------------------------------------------------------------------------
// float_to_int_truncate
// Single-precision to signed integer conversion, truncating toward zero.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle while the skid register is empty.
// The conversion is a single shifter and compare stage between the input
// port and the result register; a skid register on the output holds one
// result during an output stall, and input is stalled while it is occupied.
module float_to_int_truncate import f2i_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  f2i_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output f2i_out_t out_data_o
);

  logic     res_valid_q, skid_valid_q;
  f2i_out_t res_q, skid_q, conv;

  f2i_convert u_convert (
    .item_i (in_data_i),
    .res_o  (conv)
  );

  // Stall input only while the skid register is occupied.
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  // Control: result register with skid buffer behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!res_valid_q || !out_stall_i) begin
        res_valid_q  <= skid_valid_q || in_valid_i;
        skid_valid_q <= 1'b0;
      end else if (in_valid_i && !skid_valid_q) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (!res_valid_q || !out_stall_i) begin
      res_q <= skid_valid_q ? skid_q : conv;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_q <= conv;
    end
  end

endmodule

// ===== hw/rtl/f2i_checker.sv =====
// ----------------------------------------------------------------------------
// f2i_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "float_to_int_truncate_assert.svh"

module f2i_checker import f2i_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input f2i_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input f2i_out_t out_data_o
);

  // A successful result always carries the ok status.
  `F2I_ASSERT_IMP(a_ok_status, clk_i, rst_ni, out_valid_o, (out_data_o.ok_flag == (out_data_o.status == StatusOk)), "ok flag and status disagree")

  // An accepted input with a free output yields a result next cycle.
  `F2I_ASSERT_NEXT(a_latency, clk_i, rst_ni, in_valid_i && !in_stall_o && !out_stall_i, out_valid_o, "result missing after one cycle")

  // Overflow always returns zero.
  `F2I_ASSERT_IMP(a_ovf_zero, clk_i, rst_ni, out_valid_o && out_data_o.status == StatusOverflow, out_data_o.int_result == 64'sd0, "overflow result not zero")

  // A stalled result holds.
  `F2I_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

endmodule

bind float_to_int_truncate f2i_checker u_f2i_checker (.*);

// ===== sim/float_to_int_truncate_tb.sv =====
// ----------------------------------------------------------------------------
// float_to_int_truncate_tb
// Drives single-precision values with every target type through the converter
// under random bursts and output stalls. Each result is checked field by field
// against a behavioural prediction of the truncation held in a queue.
// ----------------------------------------------------------------------------
module float_to_int_truncate_tb;
  import f2i_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  f2i_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  f2i_out_t out_data_o;

  f2i_out_t    pending_conv_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          hold_off_req = 1'b0;
  bit          stall_random = 1'b1;

  float_to_int_truncate uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Prediction of one conversion: truncate toward zero, then range check.
  function automatic f2i_out_t convert_truncate(f2i_in_t item);
    f2i_out_t    res;
    logic        neg;
    logic [7:0]  expo;
    logic [63:0] mant;
    logic [63:0] mag;
    int unsigned e;
    logic        fits;
    neg  = item.real_bits[31];
    expo = item.real_bits[30:23];
    mant = {40'd0, 1'b1, item.real_bits[22:0]};
    res  = '0;
    if (expo == 8'hFF) begin
      res.status = StatusInvalid;
      if (item.func == FuncI32) res.int_result = MinI32Ext;
      else if (item.func == FuncI64) res.int_result = MinI64;
      return res;
    end
    if (expo < 8'd127) begin
      mag = '0;
    end else begin
      e = 32'(expo) - 32'd127;
      if (e >= 63) begin
        res.status = StatusOverflow;
        return res;
      end
      if (e <= 23) mag = mant >> (23 - e);
      else mag = mant << (e - 23);
    end
    case (item.func)
      FuncI8:  fits = neg ? (mag <= 64'd128) : (mag <= 64'd127);
      FuncI16: fits = neg ? (mag <= 64'd32768) : (mag <= 64'd32767);
      default: fits = mag < 64'd16777216;
    endcase
    if (!fits) begin
      res.status = StatusOverflow;
      return res;
    end
    res.int_result = neg ? -mag : mag;
    res.ok_flag    = 1'b1;
    res.status     = StatusOk;
    return res;
  endfunction

  // Offers one transaction and holds it until the block takes it.
  task automatic send_value(input logic [1:0] func, input logic [31:0] bits);
    f2i_in_t item;
    item.func      = func;
    item.real_bits = bits;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    pending_conv_q.push_back(convert_truncate(item));
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    go_idle();
    do @(posedge clk_i); while (pending_conv_q.size() != 0);
  endtask

  // Random value biased toward interesting exponents.
  function automatic logic [31:0] random_real();
    logic [31:0] bits;
    bits = $urandom;
    case ($urandom_range(0, 5))
      0: bits[30:23] = 8'hFF;
      1: bits[30:23] = 8'd0;
      2, 3: bits[30:23] = 8'($urandom_range(120, 158));
      default: ;
    endcase
    return bits;
  endfunction

  task automatic test_directed();
    logic [31:0] vals[] = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
      32'h3F7F_FFFF, 32'hBFC0_0000, 32'h42FE_0000, 32'h4300_0000,
      32'hC300_0000, 32'hC301_0000, 32'h46FF_FE00, 32'hC700_0000,
      32'h4B7F_FFFF, 32'h4B80_0000, 32'hCB7F_FFFF, 32'h5EFF_FFFF,
      32'h5F00_0000, 32'h7F80_0000, 32'hFFC0_0001, 32'h7FFF_FFFF,
      32'hFF7F_FFFF};
    foreach (vals[i]) send_value(2'(i % 4), vals[i]);
    for (int f = 0; f < 4; f++) send_value(2'(f), 32'h7F80_0001);
    wait_drained();
  endtask

  task automatic test_random_bursts(input int unsigned count);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      repeat ($urandom_range(1, 20)) begin
        if (sent < count) send_value(2'($urandom_range(0, 3)), random_real());
        sent++;
      end
      if ($urandom_range(0, 2) == 0) begin
        go_idle();
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    repeat (40) send_value(2'($urandom_range(0, 3)), random_real());
    wait_drained();
  endtask

  // Output stall pattern, with an occasional long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      stall_random = 1'b0;
      out_stall_i <= 1'b1;
      repeat (60) @(posedge clk_i);
      out_stall_i <= 1'b0;
      stall_random = 1'b1;
    end else if (stall_random) begin
      out_stall_i <= (cycle_count[9:8] == 2'd0) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    f2i_out_t exp_res;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_conv_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, out_data_o);
        error_count++;
      end else begin
        exp_res = pending_conv_q.pop_front();
        if (out_data_o.int_result !== exp_res.int_result) begin
          $display("%0t: int_result expected %h actual %h", $time,
                   exp_res.int_result, out_data_o.int_result);
          error_count++;
        end
        if (out_data_o.ok_flag !== exp_res.ok_flag) begin
          $display("%0t: ok_flag expected %b actual %b", $time,
                   exp_res.ok_flag, out_data_o.ok_flag);
          error_count++;
        end
        if (out_data_o.status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_res.status, out_data_o.status);
          error_count++;
        end
      end
    end
    if (cycle_count >= CycleLimit) begin
      $display("float_to_int_truncate_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_bursts(800);
    test_backpressure();
    test_random_bursts(760);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && pending_conv_q.size() == 0) begin
      $display("float_to_int_truncate_tb: PASS");
    end else begin
      $display("float_to_int_truncate_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/f2i_pkg.sv
hw/rtl/f2i_convert.sv
hw/rtl/float_to_int_truncate.sv
hw/rtl/f2i_checker.sv
sim/float_to_int_truncate_tb.sv
